// File: rtl/device_heartbeat_offline_monitor_macros.svh
// Assertion macros for the heartbeat offline monitor.
// Used by the top level only; the macros are empty when SYNTHESIS is defined.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef DEVICE_HEARTBEAT_OFFLINE_MONITOR_MACROS_SVH
`define DEVICE_HEARTBEAT_OFFLINE_MONITOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define DHOM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define DHOM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DHOM_ASSERT_IMP(lbl, ante, cons)
`define DHOM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/dhom_pkg.sv
// Shared types and constants for the heartbeat offline monitor.
// No dependencies; used by dhom_ctrl, dhom_dp and the top level.
package dhom_pkg;

    // Default table size
    localparam int NUM_DEVICES_DEF = 16;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int DEV_W   = 4;
    localparam int LIMIT_W = 16;
    localparam int PRI_W   = 8;
    localparam int MASK_W  = 16;
    localparam int TOP_W   = 5;

    // Item opcodes
    localparam logic [MODE_W-1:0] MODE_SCAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;

    // top_device code when no offline device qualifies
    localparam logic [TOP_W-1:0] NO_DEVICE = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the item, clear scan accumulators
        logic exec;       // apply a heartbeat or set-device item
        logic scan_step;  // check one table entry
        logic finish;     // load the result registers
    } dhom_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;  // current entry is the last one
    } dhom_stat_t;

endpackage

// File: rtl/dhom_ctrl.sv
// Controller state machine for the heartbeat offline monitor.
// Depends on dhom_pkg; drives dhom_dp through dhom_cmd_t.
module dhom_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dhom_pkg::MODE_W-1:0]   mode,
    input  dhom_pkg::dhom_stat_t          stat,
    output dhom_pkg::dhom_cmd_t           cmd,
    output logic                          busy,
    output logic                          done
);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } dhom_state_t;

    dhom_state_t state_reg;
    dhom_state_t state_next;
    logic        done_reg;
    logic        done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (mode == dhom_pkg::MODE_SCAN)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/dhom_dp.sv
// Datapath for the heartbeat offline monitor: device table, flags, scan unit.
// Depends on dhom_pkg; sequenced by dhom_ctrl.
module dhom_dp
#(
    parameter int NUM_DEVICES = dhom_pkg::NUM_DEVICES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dhom_pkg::dhom_cmd_t             cmd,
    output dhom_pkg::dhom_stat_t            stat,
    input  logic [dhom_pkg::MODE_W-1:0]     mode,
    input  logic [dhom_pkg::TIME_W-1:0]     now,
    input  logic [dhom_pkg::DEV_W-1:0]      device,
    input  logic                            data_bad,
    input  logic [dhom_pkg::LIMIT_W-1:0]    offline_limit,
    input  logic [dhom_pkg::LIMIT_W-1:0]    settle_limit,
    input  logic [dhom_pkg::PRI_W-1:0]      priority_req,
    input  logic                            enable,
    output logic [dhom_pkg::MASK_W-1:0]     error_mask,
    output logic [dhom_pkg::MASK_W-1:0]     lost_mask,
    output logic [dhom_pkg::MASK_W-1:0]     offline_mask,
    output logic                            any_offline,
    output logic [dhom_pkg::TOP_W-1:0]      top_device,
    output logic                            data_fault
);

    localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    // Latched item
    logic [dhom_pkg::MODE_W-1:0]  mode_reg;
    logic [dhom_pkg::TIME_W-1:0]  now_reg;
    logic [dhom_pkg::DEV_W-1:0]   device_reg;
    logic                         bad_reg;
    logic [dhom_pkg::LIMIT_W-1:0] off_lim_reg;
    logic [dhom_pkg::LIMIT_W-1:0] set_lim_reg;
    logic [dhom_pkg::PRI_W-1:0]   pri_reg;
    logic                         en_reg;

    // Device table
    logic [dhom_pkg::TIME_W-1:0]  heard_reg    [NUM_DEVICES];
    logic [dhom_pkg::TIME_W-1:0]  settle_reg   [NUM_DEVICES];
    logic [dhom_pkg::LIMIT_W-1:0] off_tab_reg  [NUM_DEVICES];
    logic [dhom_pkg::LIMIT_W-1:0] set_tab_reg  [NUM_DEVICES];
    logic [dhom_pkg::PRI_W-1:0]   pri_tab_reg  [NUM_DEVICES];

    // Per-device flags
    logic [NUM_DEVICES-1:0] enabled_reg;
    logic [NUM_DEVICES-1:0] error_reg;
    logic [NUM_DEVICES-1:0] lost_reg;
    logic [NUM_DEVICES-1:0] fault_reg;

    // Scan walker and accumulators
    logic [IDX_W-1:0]             idx_reg;
    logic [dhom_pkg::PRI_W-1:0]   best_reg;
    logic [dhom_pkg::TOP_W-1:0]   top_reg;
    logic [NUM_DEVICES-1:0]       offl_reg;
    logic                         any_reg;
    logic                         hit_reg;

    // Result registers
    logic [dhom_pkg::MASK_W-1:0]  error_mask_reg;
    logic [dhom_pkg::MASK_W-1:0]  lost_mask_reg;
    logic [dhom_pkg::MASK_W-1:0]  offline_mask_reg;
    logic                         any_offline_reg;
    logic [dhom_pkg::TOP_W-1:0]   top_device_reg;
    logic                         data_fault_reg;

    logic                         dev_ok;
    logic [IDX_W-1:0]             dev_idx;
    logic [dhom_pkg::TIME_W-1:0]  heard_age;
    logic [dhom_pkg::TIME_W-1:0]  settle_age;
    logic                         is_offline;
    logic                         is_settling;
    logic                         scan_en;
    logic [dhom_pkg::MASK_W-1:0]  err_view;
    logic [dhom_pkg::MASK_W-1:0]  lost_view;
    logic [dhom_pkg::MASK_W-1:0]  offl_view;

    // Addressed device decode
    assign dev_ok  = ({2'b00, device_reg} < 6'(NUM_DEVICES));
    assign dev_idx = IDX_W'(device_reg);

    // Entry check for the current scan slot, wrapping differences
    assign heard_age   = now_reg - heard_reg[idx_reg];
    assign settle_age  = now_reg - settle_reg[idx_reg];
    assign is_offline  = heard_age > {16'b0, off_tab_reg[idx_reg]};
    assign is_settling = settle_age < {16'b0, set_tab_reg[idx_reg]};
    assign scan_en     = cmd.scan_step && enabled_reg[idx_reg];

    assign stat.scan_last = (idx_reg == IDX_W'(NUM_DEVICES - 1));

    // Only slots 0..15 appear in the masks
    genvar g;
    generate
        for (g = 0; g < dhom_pkg::MASK_W; g++)
        begin : g_view
            if (g < NUM_DEVICES)
            begin : g_live
                assign err_view[g]  = error_reg[g];
                assign lost_view[g] = lost_reg[g];
                assign offl_view[g] = offl_reg[g];
            end
            else
            begin : g_none
                assign err_view[g]  = 1'b0;
                assign lost_view[g] = 1'b0;
                assign offl_view[g] = 1'b0;
            end
        end
    endgenerate

    // Item latch on accepted transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            now_reg     <= now;
            device_reg  <= device;
            bad_reg     <= data_bad;
            off_lim_reg <= offline_limit;
            set_lim_reg <= settle_limit;
            pri_reg     <= priority_req;
            en_reg      <= enable;
        end
    end

    // Table writes; an entry is always set up before a scan reads it
    always_ff @(posedge clk)
    begin
        if (cmd.exec && dev_ok)
        begin
            case (mode_reg)
                dhom_pkg::MODE_BEAT:
                begin
                    heard_reg[dev_idx] <= now_reg;
                    if (lost_reg[dev_idx])
                        settle_reg[dev_idx] <= now_reg;
                end
                dhom_pkg::MODE_SET:
                begin
                    heard_reg[dev_idx]   <= now_reg;
                    settle_reg[dev_idx]  <= now_reg;
                    off_tab_reg[dev_idx] <= off_lim_reg;
                    set_tab_reg[dev_idx] <= set_lim_reg;
                    pri_tab_reg[dev_idx] <= pri_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Flag updates from heartbeats, set-device items and scan steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
            error_reg   <= '1;
            lost_reg    <= '1;
            fault_reg   <= '1;
        end
        else if (cmd.exec && dev_ok)
        begin
            case (mode_reg)
                dhom_pkg::MODE_BEAT:
                begin
                    lost_reg[dev_idx] <= 1'b0;
                    if (bad_reg)
                    begin
                        error_reg[dev_idx] <= 1'b1;
                        fault_reg[dev_idx] <= 1'b1;
                    end
                    else
                    begin
                        fault_reg[dev_idx] <= 1'b0;
                    end
                end
                dhom_pkg::MODE_SET:
                begin
                    enabled_reg[dev_idx] <= en_reg;
                    error_reg[dev_idx]   <= 1'b1;
                    lost_reg[dev_idx]    <= 1'b1;
                    fault_reg[dev_idx]   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (scan_en)
        begin
            if (is_offline)
            begin
                // offline and not yet in error: raise both flags
                if (!error_reg[idx_reg])
                begin
                    lost_reg[idx_reg]  <= 1'b1;
                    error_reg[idx_reg] <= 1'b1;
                end
            end
            else if (is_settling)
            begin
                lost_reg[idx_reg]  <= 1'b0;
                error_reg[idx_reg] <= 1'b1;
            end
            else
            begin
                lost_reg[idx_reg]  <= 1'b0;
                error_reg[idx_reg] <= fault_reg[idx_reg];
            end
        end
    end

    // Scan walker, offline set, fault hit, priority pick (strictly greater wins)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            best_reg <= '0;
            top_reg  <= dhom_pkg::NO_DEVICE;
            offl_reg <= '0;
            any_reg  <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            idx_reg  <= '0;
            best_reg <= '0;
            top_reg  <= dhom_pkg::NO_DEVICE;
            offl_reg <= '0;
            any_reg  <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec && dev_ok && mode_reg == dhom_pkg::MODE_BEAT && bad_reg)
                hit_reg <= 1'b1;
            if (cmd.scan_step)
                idx_reg <= idx_reg + 1'b1;
            if (scan_en && is_offline)
            begin
                offl_reg[idx_reg] <= 1'b1;
                any_reg           <= 1'b1;
                if (pri_tab_reg[idx_reg] > best_reg)
                begin
                    best_reg <= pri_tab_reg[idx_reg];
                    top_reg  <= dhom_pkg::TOP_W'(idx_reg);
                end
            end
        end
    end

    // Result registers, loaded once the item has settled
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            error_mask_reg   <= err_view;
            lost_mask_reg    <= lost_view;
            offline_mask_reg <= offl_view;
            any_offline_reg  <= any_reg;
            top_device_reg   <= top_reg;
            data_fault_reg   <= hit_reg;
        end
    end

    assign error_mask   = error_mask_reg;
    assign lost_mask    = lost_mask_reg;
    assign offline_mask = offline_mask_reg;
    assign any_offline  = any_offline_reg;
    assign top_device   = top_device_reg;
    assign data_fault   = data_fault_reg;

endmodule

// File: rtl/device_heartbeat_offline_monitor.sv
// Top level of the per-device heartbeat watchdog.
// Depends on dhom_pkg, dhom_ctrl, dhom_dp and the assertion macro header.
//
// Channel   Handshake              Fields
// command   start / busy           mode, now, device, data_bad, offline_limit,
//                                  settle_limit, priority_req, enable
// result    done (one-cycle pulse) error_mask, lost_mask, offline_mask,
//                                  any_offline, top_device, data_fault
//
// A command transfer happens at an edge with start high and busy low.
// A scan walks the table one entry per cycle, then the done state; heartbeat
// and set-device pass exec and done. No new command is taken until idle.
// done pulses in the cycle after the item completes; busy is already low then.
// Results cannot be stalled. rst_n resets the controller and all flags.
`include "device_heartbeat_offline_monitor_macros.svh"
module device_heartbeat_offline_monitor
#(
    parameter int NUM_DEVICES = dhom_pkg::NUM_DEVICES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dhom_pkg::MODE_W-1:0]     mode,
    input  logic [dhom_pkg::TIME_W-1:0]     now,
    input  logic [dhom_pkg::DEV_W-1:0]      device,
    input  logic                            data_bad,
    input  logic [dhom_pkg::LIMIT_W-1:0]    offline_limit,
    input  logic [dhom_pkg::LIMIT_W-1:0]    settle_limit,
    input  logic [dhom_pkg::PRI_W-1:0]      priority_req,
    input  logic                            enable,
    output logic                            done,
    output logic [dhom_pkg::MASK_W-1:0]     error_mask,
    output logic [dhom_pkg::MASK_W-1:0]     lost_mask,
    output logic [dhom_pkg::MASK_W-1:0]     offline_mask,
    output logic                            any_offline,
    output logic [dhom_pkg::TOP_W-1:0]      top_device,
    output logic                            data_fault
);

    dhom_pkg::dhom_cmd_t  cmd;
    dhom_pkg::dhom_stat_t stat;

    // Sequencer
    dhom_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Table, flags and scan unit
    dhom_dp #(.NUM_DEVICES(NUM_DEVICES)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .now           (now),
        .device        (device),
        .data_bad      (data_bad),
        .offline_limit (offline_limit),
        .settle_limit  (settle_limit),
        .priority_req  (priority_req),
        .enable        (enable),
        .error_mask    (error_mask),
        .lost_mask     (lost_mask),
        .offline_mask  (offline_mask),
        .any_offline   (any_offline),
        .top_device    (top_device),
        .data_fault    (data_fault)
    );

    // Checks
    `DHOM_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)
    `DHOM_ASSERT_IMP(a_done_idle, done, !busy)
    `DHOM_ASSERT_IMP(a_any_mask, done, any_offline == (offline_mask != '0))
    `DHOM_ASSERT_IMP(a_top_any, done && top_device != dhom_pkg::NO_DEVICE, any_offline)

endmodule
